>>> hdl/tlab_bump_allocator_assert.svh
// ----------------------------------------------------------------------------
// tlab_bump_allocator_assert.svh
// Assertion macros for the bump allocator; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TLAB_BUMP_ALLOCATOR_ASSERT_SVH
`define TLAB_BUMP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlab_bump_allocator: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlab_bump_allocator: assertion failed");

`else

`define TBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg
// Command and status codes, field widths and word types of the bump allocator.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int ADDR_BITS_DEF  = 32;
    localparam int TOTAL_BITS_DEF = 48;

    localparam int WORD_W      = 32;
    localparam int ALIGN_W     = 16;
    localparam int TOTAL_OUT_W = 48;

    localparam logic [WORD_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_RETIRE = 2'd1,
        CMD_REFILL = 2'd2,
        CMD_INIT   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_ALIGN      = 3'd2,
        ST_BAD_REGION = 3'd3,
        ST_BOUNDS     = 3'd4,
        ST_OVERFLOW   = 3'd5,
        ST_EXHAUSTED  = 3'd6,
        ST_SAFEPOINT  = 3'd7
    } status_t;

    typedef struct packed {
        cmd_code_t           command;
        logic [WORD_W-1:0]   size;
        logic [ALIGN_W-1:0]  alignment;
        logic [WORD_W-1:0]   base_addr;
        logic [WORD_W-1:0]   region_bytes;
        logic [WORD_W-1:0]   region_id;
        logic [WORD_W-1:0]   waste_limit;
        logic                at_safepoint;
    } cmd_word_t;

    typedef struct packed {
        status_t                 status;
        logic [WORD_W-1:0]       address;
        logic                    active;
        logic [WORD_W-1:0]       alloc_count;
        logic [WORD_W-1:0]       refill_count;
        logic [TOTAL_OUT_W-1:0]  retired_total;
        logic [TOTAL_OUT_W-1:0]  waste_total;
    } rsp_word_t;

endpackage

>>> hdl/tba_cmd_if.sv
// ----------------------------------------------------------------------------
// tba_cmd_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface tba_cmd_if import tba_pkg::*;;

    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [WORD_W-1:0]  size;
    logic [ALIGN_W-1:0] alignment;
    logic [WORD_W-1:0]  base_addr;
    logic [WORD_W-1:0]  region_bytes;
    logic [WORD_W-1:0]  region_id;
    logic [WORD_W-1:0]  waste_limit;
    logic               at_safepoint;

    modport source (
        output valid, command, size, alignment, base_addr, region_bytes,
               region_id, waste_limit, at_safepoint,
        input  ready
    );

    modport sink (
        input  valid, command, size, alignment, base_addr, region_bytes,
               region_id, waste_limit, at_safepoint,
        output ready
    );

endinterface

>>> hdl/tba_rsp_if.sv
// ----------------------------------------------------------------------------
// tba_rsp_if
// Response channel: valid/ready handshake with one response word.
// ----------------------------------------------------------------------------
interface tba_rsp_if import tba_pkg::*;;

    logic                   valid;
    logic                   ready;
    logic [2:0]             status;
    logic [WORD_W-1:0]      address;
    logic                   active;
    logic [WORD_W-1:0]      alloc_count;
    logic [WORD_W-1:0]      refill_count;
    logic [TOTAL_OUT_W-1:0] retired_total;
    logic [TOTAL_OUT_W-1:0] waste_total;

    modport source (
        output valid, status, address, active, alloc_count, refill_count,
               retired_total, waste_total,
        input  ready
    );

    modport sink (
        input  valid, status, address, active, alloc_count, refill_count,
               retired_total, waste_total,
        output ready
    );

endinterface

>>> hdl/tba_core.sv
// ----------------------------------------------------------------------------
// tba_core
// Allocator state registers and the single-pass step logic for one command.
// ----------------------------------------------------------------------------
module tba_core import tba_pkg::*; #(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  cmd_word_t item,
    output rsp_word_t result
);

    localparam int AW  = ADDR_BITS;
    localparam int AW1 = AW + 1;
    localparam int SW  = ((AW > WORD_W) ? AW : WORD_W) + 1;
    localparam int TW  = TOTAL_BITS;
    localparam int TW1 = TW + 1;

    localparam logic [SW-1:0] ADDR_MAX_W = SW'({AW{1'b1}});

    // Region base, tag and waste bound are never read back, so they are not kept.
    logic [AW-1:0]     cursor_reg,   cursor_next;
    logic [AW-1:0]     end_reg,      end_next;
    logic [WORD_W-1:0] cap_reg,      cap_next;
    logic              active_reg,   active_next;
    logic [WORD_W-1:0] alloc_reg,    alloc_next;
    logic [WORD_W-1:0] refill_reg,   refill_next;
    logic [TW-1:0]     retired_reg,  retired_next;
    logic [TW-1:0]     waste_reg,    waste_next;

    logic [ALIGN_W-1:0] align_mask;
    logic               align_ok;
    logic [AW-1:0]      pad;
    logic [AW:0]        aligned_w;
    logic               pad_ovf;
    logic [SW-1:0]      obj_end;
    logic               fits;

    logic [SW-1:0]      rgn_end_w;
    logic               rgn_ok;
    logic [WORD_W-1:0]  quarter;
    logic [WORD_W-1:0]  waste_pick;
    logic               waste_big;

    logic [WORD_W-1:0]  tail;
    logic [TW:0]        ret_sum_w;
    logic [TW:0]        waste_sum_w;
    logic               ret_ovf;

    status_t            status;
    logic [WORD_W-1:0]  address;

    // Allocate datapath: align up, then check the object end against the region end.
    assign align_mask = item.alignment - 1'b1;
    assign align_ok   = (item.alignment != '0) && ((item.alignment & align_mask) == '0);
    assign pad        = (AW'(0) - cursor_reg) & AW'(align_mask);
    assign aligned_w  = AW1'(cursor_reg) + AW1'(pad);
    assign pad_ovf    = aligned_w[AW];
    assign obj_end    = SW'(aligned_w[AW-1:0]) + SW'(item.size);
    assign fits       = obj_end <= SW'(end_reg);

    // Region check and waste limit for refill and init.
    assign rgn_end_w  = SW'(item.base_addr) + SW'(item.region_bytes);
    assign rgn_ok     = (item.base_addr != '0) && (item.region_bytes != '0)
                        && (item.region_id != '0)
                        && (SW'(item.base_addr) <= ADDR_MAX_W)
                        && (rgn_end_w <= ADDR_MAX_W);
    assign quarter    = item.region_bytes >> 2;
    assign waste_pick = (item.waste_limit != '0) ? item.waste_limit
                      : ((quarter != '0) ? quarter : WORD_W'(1));
    assign waste_big  = waste_pick > item.region_bytes;

    // Retire sums; the tail never exceeds the capacity, so it fits a word.
    assign tail        = WORD_W'(end_reg - cursor_reg);
    assign ret_sum_w   = TW1'(retired_reg) + TW1'(cap_reg);
    assign waste_sum_w = TW1'(waste_reg) + TW1'(tail);
    assign ret_ovf     = ret_sum_w[TW] || waste_sum_w[TW];

    always_comb
    begin
        cursor_next  = cursor_reg;
        end_next     = end_reg;
        cap_next     = cap_reg;
        active_next  = active_reg;
        alloc_next   = alloc_reg;
        refill_next  = refill_reg;
        retired_next = retired_reg;
        waste_next   = waste_reg;
        status       = ST_OK;
        address      = '0;

        case (item.command)
            CMD_ALLOC:
            begin
                if (item.size == '0)
                    status = ST_INVALID;
                else if (!align_ok)
                    status = ST_ALIGN;
                else if (!active_reg)
                    status = ST_EXHAUSTED;
                else if (pad_ovf)
                    status = ST_OVERFLOW;
                else if (!fits)
                    status = ST_EXHAUSTED;
                else if (alloc_reg == COUNT_MAX)
                    status = ST_OVERFLOW;
                else
                begin
                    cursor_next = AW'(obj_end);
                    alloc_next  = alloc_reg + 1'b1;
                    address     = WORD_W'(aligned_w[AW-1:0]);
                end
            end
            CMD_RETIRE:
            begin
                if (active_reg)
                begin
                    if (ret_ovf)
                        status = ST_OVERFLOW;
                    else
                    begin
                        retired_next = ret_sum_w[TW-1:0];
                        waste_next   = waste_sum_w[TW-1:0];
                        cursor_next  = '0;
                        end_next     = '0;
                        cap_next     = '0;
                        active_next  = 1'b0;
                    end
                end
            end
            CMD_REFILL:
            begin
                if (!rgn_ok)
                    status = ST_INVALID;
                else if (!item.at_safepoint)
                    status = ST_SAFEPOINT;
                else if (waste_big || (refill_reg == COUNT_MAX))
                    status = ST_OVERFLOW;
                else if (active_reg && ret_ovf)
                    status = ST_OVERFLOW;
                else
                begin
                    if (active_reg)
                    begin
                        retired_next = ret_sum_w[TW-1:0];
                        waste_next   = waste_sum_w[TW-1:0];
                    end
                    cursor_next = AW'(item.base_addr);
                    end_next    = AW'(rgn_end_w);
                    cap_next    = item.region_bytes;
                    active_next = 1'b1;
                    refill_next = refill_reg + 1'b1;
                end
            end
            CMD_INIT:
            begin
                alloc_next   = '0;
                refill_next  = '0;
                retired_next = '0;
                waste_next   = '0;
                if (!rgn_ok || waste_big)
                begin
                    status      = ST_INVALID;
                    cursor_next = '0;
                    end_next    = '0;
                    cap_next    = '0;
                    active_next = 1'b0;
                end
                else
                begin
                    cursor_next = AW'(item.base_addr);
                    end_next    = AW'(rgn_end_w);
                    cap_next    = item.region_bytes;
                    active_next = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        result.status        = status;
        result.address       = address;
        result.active        = active_next;
        result.alloc_count   = alloc_next;
        result.refill_count  = refill_next;
        result.retired_total = TOTAL_OUT_W'(retired_next);
        result.waste_total   = TOTAL_OUT_W'(waste_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            end_reg     <= '0;
            cap_reg     <= '0;
            active_reg  <= 1'b0;
            alloc_reg   <= '0;
            refill_reg  <= '0;
            retired_reg <= '0;
            waste_reg   <= '0;
        end
        else if (step)
        begin
            cursor_reg  <= cursor_next;
            end_reg     <= end_next;
            cap_reg     <= cap_next;
            active_reg  <= active_next;
            alloc_reg   <= alloc_next;
            refill_reg  <= refill_next;
            retired_reg <= retired_next;
            waste_reg   <= waste_next;
        end
    end

endmodule

>>> hdl/tlab_bump_allocator.sv
// ----------------------------------------------------------------------------
// tlab_bump_allocator
// Thread-local bump allocator over one region, one command word per cycle when not stalled.
// ----------------------------------------------------------------------------
// The allocator takes one command word per clock, unless stalled, and returns
// exactly one response word for each, in order. A command is captured in an input
// register, evaluated against the region state in a single pass (align the
// cursor, add the object size, compare with the region end, or the retire and
// refill sums), and the response lands in the output register when the command
// advances. Commands stream back to back at one per cycle while nothing stalls;
// the rate is set by the cursor update loop, which closes through one align add,
// one size add and one compare in a cycle. The input register keeps taking
// words while a response waits on the output side and stalls only when both
// registers are full and the waiting response word is not being taken. Every
// counter and total in a response is the value after that command; a failed
// command returns address zero and leaves the state alone, except that init
// always clears the counters first and a refused init also drops the region.
// ----------------------------------------------------------------------------
`include "tlab_bump_allocator_assert.svh"

module tlab_bump_allocator import tba_pkg::*; #(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tba_cmd_if.sink       cmd,
    tba_rsp_if.source     rsp
);

    // Input stage: holds one accepted command word.
    logic      in_vld_reg, in_vld_next;
    cmd_word_t in_reg;

    // Output stage: holds one finished response word.
    logic      rsp_vld_reg, rsp_vld_next;
    rsp_word_t rsp_reg;

    logic      cmd_fire;
    logic      advance;
    rsp_word_t step_result;

    // Advance the held command whenever the output register is free or draining.
    assign advance  = in_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign cmd.ready = !in_vld_reg || advance;
    assign cmd_fire = cmd.valid && cmd.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (cmd_fire)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        rsp_vld_next = rsp_vld_reg;
        if (advance)
            rsp_vld_next = 1'b1;
        else if (rsp.ready)
            rsp_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            in_reg.command      <= cmd_code_t'(cmd.command);
            in_reg.size         <= cmd.size;
            in_reg.alignment    <= cmd.alignment;
            in_reg.base_addr    <= cmd.base_addr;
            in_reg.region_bytes <= cmd.region_bytes;
            in_reg.region_id    <= cmd.region_id;
            in_reg.waste_limit  <= cmd.waste_limit;
            in_reg.at_safepoint <= cmd.at_safepoint;
        end
        if (advance)
            rsp_reg <= step_result;
    end

    // State update and response for the held command, committed on advance.
    tba_core #(
        .ADDR_BITS  (ADDR_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_reg),
        .result (step_result)
    );

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.status        = rsp_reg.status;
    assign rsp.address       = rsp_reg.address;
    assign rsp.active        = rsp_reg.active;
    assign rsp.alloc_count   = rsp_reg.alloc_count;
    assign rsp.refill_count  = rsp_reg.refill_count;
    assign rsp.retired_total = rsp_reg.retired_total;
    assign rsp.waste_total   = rsp_reg.waste_total;

    // A stalled command stays put until it can advance.
    `TBA_ASSERT_NEXT(a_hold_cmd, clk, rst_n, in_vld_reg && !advance,
                     in_vld_reg && $stable(in_reg))
    // Every step produces a response in the next cycle.
    `TBA_ASSERT_NEXT(a_step_rsp, clk, rst_n, advance, rsp_vld_reg)
    // A failed command never reports an address.
    `TBA_ASSERT_IMPLIES(a_err_addr, clk, rst_n, rsp_vld_reg && (rsp_reg.status != ST_OK),
                        rsp_reg.address == '0)

endmodule

>>> tb/sv/tlab_bump_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlab_bump_allocator_test
// Self-checking bench for the bump allocator. A directed list covers region
// checks, alignment errors, exhaustion and the top of the address space.
// Random region lifetimes follow: load, allocation burst, often a retire, with
// noise words mixed in. Both channel sides idle at random. Each response word
// is checked against a cycle-free shadow of the allocator state.
// ----------------------------------------------------------------------------
module tlab_bump_allocator_test;
    import tba_pkg::*;

    localparam int          ITEM_TARGET  = 1275;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [63:0] ADDR_LIMIT   = (64'd1 << ADDR_BITS_DEF) - 64'd1;
    localparam logic [63:0] TOTAL_LIMIT  = (64'd1 << TOTAL_BITS_DEF) - 64'd1;

    logic clk;
    logic rst_n;

    tba_cmd_if cmd_bus ();
    tba_rsp_if rsp_bus ();

    tlab_bump_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Command words waiting to be driven, and response words still owed.
    cmd_word_t cmd_backlog[$];
    rsp_word_t expected_rsp[$];
    cmd_word_t next_word;
    rsp_word_t oldest_rsp;

    int error_count = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    // ------------------------------------------------------------------------
    // Shadow of the allocator state. Held wide so that every sum and bound
    // check is done without wrapping, then cut to the port widths.
    // ------------------------------------------------------------------------
    logic [63:0] tlab_base      = '0;
    logic [63:0] tlab_cursor    = '0;
    logic [63:0] tlab_end       = '0;
    logic [63:0] tlab_cap       = '0;
    logic [63:0] tlab_id        = '0;
    logic [63:0] tlab_waste_lim = '0;
    logic        tlab_live      = 1'b0;
    logic [63:0] n_allocs       = '0;
    logic [63:0] n_refills      = '0;
    logic [63:0] sum_retired    = '0;
    logic [63:0] sum_waste      = '0;

    // Base, capacity and id must be nonzero and the region must end inside
    // the address space.
    function automatic bit region_fits(logic [63:0] base, logic [63:0] cap,
                                       logic [63:0] id);
        if (base == 0 || cap == 0 || id == 0 || base > ADDR_LIMIT)
            return 1'b0;
        return cap <= ADDR_LIMIT - base;
    endfunction

    // A zero limit falls back to a quarter of the capacity, never below one.
    function automatic logic [63:0] waste_default(logic [63:0] lim, logic [63:0] cap);
        if (lim == 0)
        begin
            lim = cap / 4;
            if (lim == 0)
                lim = 64'd1;
        end
        return lim;
    endfunction

    function automatic void drop_region();
        tlab_base      = '0;
        tlab_cursor    = '0;
        tlab_end       = '0;
        tlab_cap       = '0;
        tlab_id        = '0;
        tlab_waste_lim = '0;
        tlab_live      = 1'b0;
    endfunction

    function automatic void load_region(logic [63:0] base, logic [63:0] cap,
                                        logic [63:0] id, logic [63:0] waste);
        tlab_base      = base;
        tlab_cursor    = base;
        tlab_end       = base + cap;
        tlab_cap       = cap;
        tlab_id        = id;
        tlab_waste_lim = waste;
        tlab_live      = 1'b1;
    endfunction

    // Fold capacity and unused tail into the totals; refuse on total overflow.
    function automatic status_t retire_tlab();
        logic [63:0] tail;
        if (!tlab_live)
            return ST_OK;
        tail = tlab_end - tlab_cursor;
        if (tlab_cap > TOTAL_LIMIT - sum_retired || tail > TOTAL_LIMIT - sum_waste)
            return ST_OVERFLOW;
        sum_retired += tlab_cap;
        sum_waste   += tail;
        drop_region();
        return ST_OK;
    endfunction

    // Advance the shadow by one command word and return the response it owes.
    function automatic rsp_word_t predict_response(cmd_word_t w);
        rsp_word_t   r;
        status_t     st;
        logic [63:0] size, align, mask, pad, aligned, cap, waste;
        size    = 64'(w.size);
        align   = 64'(w.alignment);
        cap     = 64'(w.region_bytes);
        waste   = waste_default(64'(w.waste_limit), cap);
        r       = '0;
        case (w.command)
            CMD_ALLOC:
            begin
                if (size == 0)
                    st = ST_INVALID;
                else if (align == 0 || (align & (align - 1)) != 0)
                    st = ST_ALIGN;
                else if (!tlab_live)
                    st = ST_EXHAUSTED;
                else
                begin
                    mask    = align - 1;
                    pad     = (64'd0 - tlab_cursor) & mask;
                    aligned = tlab_cursor + pad;
                    if (pad > ADDR_LIMIT - tlab_cursor)
                        st = ST_OVERFLOW;
                    else if (aligned > tlab_end || size > tlab_end - aligned)
                        st = ST_EXHAUSTED;
                    else if (n_allocs >= COUNT_MAX)
                        st = ST_OVERFLOW;
                    else
                    begin
                        tlab_cursor = aligned + size;
                        n_allocs    = n_allocs + 1;
                        r.address   = aligned[WORD_W-1:0];
                        st          = ST_OK;
                    end
                end
            end
            CMD_RETIRE:
                st = retire_tlab();
            CMD_REFILL:
            begin
                if (!region_fits(64'(w.base_addr), cap, 64'(w.region_id)))
                    st = ST_INVALID;
                else if (!w.at_safepoint)
                    st = ST_SAFEPOINT;
                else if (waste > cap || n_refills >= COUNT_MAX)
                    st = ST_OVERFLOW;
                else
                begin
                    st = retire_tlab();
                    if (st == ST_OK)
                    begin
                        load_region(64'(w.base_addr), cap, 64'(w.region_id), waste);
                        n_refills = n_refills + 1;
                    end
                end
            end
            default:
            begin
                // Init clears everything even when the new region is refused.
                drop_region();
                n_allocs    = '0;
                n_refills   = '0;
                sum_retired = '0;
                sum_waste   = '0;
                if (!region_fits(64'(w.base_addr), cap, 64'(w.region_id)) || waste > cap)
                    st = ST_INVALID;
                else
                begin
                    load_region(64'(w.base_addr), cap, 64'(w.region_id), waste);
                    st = ST_OK;
                end
            end
        endcase
        r.status        = st;
        r.active        = tlab_live;
        r.alloc_count   = n_allocs[WORD_W-1:0];
        r.refill_count  = n_refills[WORD_W-1:0];
        r.retired_total = sum_retired[TOTAL_OUT_W-1:0];
        r.waste_total   = sum_waste[TOTAL_OUT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders. Fields a command does not use carry random filler,
    // so the block is also seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic cmd_word_t noise_word();
        cmd_word_t w;
        w.command      = cmd_code_t'($urandom_range(0, 3));
        w.size         = $urandom;
        w.alignment    = 16'($urandom_range(0, 16'hFFFF));
        w.base_addr    = $urandom;
        w.region_bytes = $urandom;
        w.region_id    = $urandom;
        w.waste_limit  = $urandom;
        w.at_safepoint = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic void queue_alloc(logic [31:0] size, logic [15:0] align);
        cmd_word_t w;
        w           = noise_word();
        w.command   = CMD_ALLOC;
        w.size      = size;
        w.alignment = align;
        cmd_backlog.push_back(w);
    endfunction

    function automatic void queue_region(cmd_code_t op, logic [31:0] base,
                                         logic [31:0] cap, logic [31:0] id,
                                         logic [31:0] waste, logic safe);
        cmd_word_t w;
        w              = noise_word();
        w.command      = op;
        w.base_addr    = base;
        w.region_bytes = cap;
        w.region_id    = id;
        w.waste_limit  = waste;
        w.at_safepoint = safe;
        cmd_backlog.push_back(w);
    endfunction

    function automatic void queue_retire();
        cmd_word_t w;
        w         = noise_word();
        w.command = CMD_RETIRE;
        cmd_backlog.push_back(w);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Command driver: hold the word until it is taken, then either idle for a
    // random gap or put the next word from the backlog on the bus. Every
    // accepted word advances the shadow and queues its response.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                expected_rsp.push_back(predict_response(next_word));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    cmd_bus.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_word              = cmd_backlog.pop_front();
                    cmd_bus.valid          <= 1'b1;
                    cmd_bus.command        <= next_word.command;
                    cmd_bus.size           <= next_word.size;
                    cmd_bus.alignment      <= next_word.alignment;
                    cmd_bus.base_addr      <= next_word.base_addr;
                    cmd_bus.region_bytes   <= next_word.region_bytes;
                    cmd_bus.region_id      <= next_word.region_id;
                    cmd_bus.waste_limit    <= next_word.waste_limit;
                    cmd_bus.at_safepoint   <= next_word.at_safepoint;
                    if (!quiet && $urandom_range(0, 99) < 30)
                        gap_left <= pick_gap();
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: compare each taken word with the oldest expectation,
    // and drop ready for random stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response word with no command outstanding");
                    error_count++;
                end
                else
                begin
                    oldest_rsp = expected_rsp.pop_front();
                    check_field("status", 64'(oldest_rsp.status), 64'(rsp_bus.status));
                    check_field("address", 64'(oldest_rsp.address), 64'(rsp_bus.address));
                    check_field("active", 64'(oldest_rsp.active), 64'(rsp_bus.active));
                    check_field("alloc_count", 64'(oldest_rsp.alloc_count),
                                64'(rsp_bus.alloc_count));
                    check_field("refill_count", 64'(oldest_rsp.refill_count),
                                64'(rsp_bus.refill_count));
                    check_field("retired_total", 64'(oldest_rsp.retired_total),
                                64'(rsp_bus.retired_total));
                    check_field("waste_total", 64'(oldest_rsp.waste_total),
                                64'(rsp_bus.waste_total));
                end
            end
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 99) < 30)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left    <= pick_gap() - 1;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Watchdog; also switch between idling and quiet stretches now and then.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main flow: build the stimulus, reset, drain and report.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] cap, base, id, waste;
        logic [15:0] align;
        int          burst_len;

        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_ALLOC;
        cmd_bus.size         = '0;
        cmd_bus.alignment    = '0;
        cmd_bus.base_addr    = '0;
        cmd_bus.region_bytes = '0;
        cmd_bus.region_id    = '0;
        cmd_bus.waste_limit  = '0;
        cmd_bus.at_safepoint = 1'b0;
        rsp_bus.ready        = 1'b0;

        // No region loaded yet: allocate exhausts, retire is a no-op.
        queue_alloc(32'd8, 16'd8);
        queue_retire();
        // Refused regions on init: zero base, zero id, past the top of the
        // address space, waste limit above capacity.
        queue_region(CMD_INIT, 32'h0, 32'h100, 32'h1, 32'h0, 1'b1);
        queue_region(CMD_INIT, 32'h1000, 32'h100, 32'h0, 32'h0, 1'b0);
        queue_region(CMD_INIT, 32'hFFFF_0000, 32'h0001_0000, 32'h5, 32'h0, 1'b1);
        queue_region(CMD_INIT, 32'h1000, 32'h100, 32'h1, 32'h101, 1'b1);
        // Good region, then bad arguments against it.
        queue_region(CMD_INIT, 32'h1000, 32'h100, 32'h1, 32'h0, 1'b0);
        queue_alloc(32'h0, 16'd1);
        queue_alloc(32'h10, 16'h0);
        queue_alloc(32'h10, 16'd3);
        queue_alloc(32'h10, 16'hFFFF);
        queue_alloc(32'h1, 16'd1);
        queue_alloc(32'h10, 16'h8000);
        queue_alloc(32'hFFFF_FFFF, 16'd1);
        // Fill exactly to the end, then one byte too many.
        queue_alloc(32'hFF, 16'd1);
        queue_alloc(32'h1, 16'd1);
        // Refill errors: no safepoint, waste above capacity, zero capacity.
        queue_region(CMD_REFILL, 32'h2000, 32'h40, 32'h2, 32'h0, 1'b0);
        queue_region(CMD_REFILL, 32'h2000, 32'h40, 32'h2, 32'h41, 1'b1);
        queue_region(CMD_REFILL, 32'h2000, 32'h0, 32'h2, 32'h0, 1'b1);
        // Refill at the very top of the address space; alignment padding then
        // runs past the top and overflows.
        queue_region(CMD_REFILL, 32'hFFFF_FFF0, 32'hF, 32'hFFFF_FFFF, 32'h0, 1'b1);
        queue_alloc(32'h1, 16'd1);
        queue_alloc(32'h1, 16'h8000);
        queue_alloc(32'hE, 16'd1);
        queue_retire();
        // Widest region with an all-ones waste limit, then a one-byte region.
        queue_region(CMD_INIT, 32'h1, 32'hFFFF_FFFE, 32'h7, 32'hFFFF_FFFF, 1'b1);
        queue_region(CMD_INIT, 32'h1, 32'hFFFF_FFFE, 32'h7, 32'h0, 1'b1);
        queue_alloc(32'hFFFF_FFFE, 16'd1);
        queue_region(CMD_REFILL, 32'hFFFF_FFFE, 32'h1, 32'h3, 32'h0, 1'b1);
        queue_alloc(32'h1, 16'd1);

        // Random part: mostly whole region lifetimes, some pure noise.
        while (cmd_backlog.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                cmd_backlog.push_back(noise_word());
                continue;
            end
            if ($urandom_range(0, 9) == 0)
                cap = $urandom_range(1, 32'hFFFF_FFFE);
            else
                cap = $urandom_range(1, 4096);
            base = $urandom_range(1, 32'hFFFF_FFFF - cap);
            id   = $urandom;
            if (id == 0)
                id = 1;
            case ($urandom_range(0, 9))
                0:       waste = $urandom;
                1, 2, 3: waste = $urandom_range(0, cap);
                default: waste = 32'h0;
            endcase
            // A refill without a safepoint now and then breaks the lifetime.
            queue_region($urandom_range(0, 9) < 3 ? CMD_INIT : CMD_REFILL,
                         base, cap, id, waste, $urandom_range(0, 19) != 0);
            burst_len = $urandom_range(1, 12);
            repeat (burst_len)
            begin
                if ($urandom_range(0, 9) == 0)
                    align = 16'd1 << $urandom_range(7, 15);
                else
                    align = 16'd1 << $urandom_range(0, 6);
                case ($urandom_range(0, 19))
                    0:       queue_alloc($urandom, 16'($urandom_range(0, 16'hFFFF)));
                    1:       queue_alloc($urandom_range(1, cap), align);
                    2:       queue_alloc(32'h0, align);
                    default: queue_alloc($urandom_range(1, (cap >> 2) + 1), align);
                endcase
            end
            if ($urandom_range(0, 9) < 6)
                queue_retire();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last command word to be taken and every response word
        // to come back, then watch a few more cycles for strays.
        while (cmd_backlog.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
